>>> rtl/hfps_pkg.sv
// ----------------------------------------------------------------------------
// hfps_pkg
// Shared types and constants for the heap file page store.
// ----------------------------------------------------------------------------
package hfps_pkg;

    localparam int MAX_PAGES      = 16;
    localparam int SLOTS_PER_PAGE = 64;

    localparam int PAGE_W  = $clog2(MAX_PAGES);
    localparam int SLOT_W  = $clog2(SLOTS_PER_PAGE);
    localparam int PCNT_W  = $clog2(MAX_PAGES + 1);
    localparam int FILL_W  = $clog2(SLOTS_PER_PAGE + 1);
    localparam int ADDR_W  = PAGE_W + SLOT_W;
    localparam int KEY_W   = 32;
    localparam int BYTES_W = 12;
    localparam int NEED_W  = 13;
    localparam int CFG_W   = 13;

    localparam int HDR_BYTES      = 16;
    localparam int SLOT_OVERHEAD  = 4;
    localparam int MAX_PAGE_BYTES = 4096;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_STATUS = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        OC_OK         = 2'd0,
        OC_PAGE_LIMIT = 2'd1,
        OC_TOO_LARGE  = 2'd2
    } t_outcome;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SCAN,
        S_SRCH_PAGE,
        S_SRCH_CMP,
        S_STATUS
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [KEY_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        t_outcome          outcome;
        logic              found;
        logic [PAGE_W-1:0] page;
        logic [SLOT_W-1:0] slot;
        logic [PCNT_W-1:0] pages;
        logic [FILL_W-1:0] recs;
        logic              last;
    } t_result;

endpackage

>>> rtl/hfps_key_ram.sv
// ----------------------------------------------------------------------------
// hfps_key_ram
// Key slot memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module hfps_key_ram
    import hfps_pkg::*;
(
    input  logic             i_clk,
    input  t_ram_req         i_req,
    output logic [KEY_W-1:0] o_rd_data
);

    logic [KEY_W-1:0] r_mem [SLOTS_PER_PAGE*MAX_PAGES];
    logic [KEY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        // read data holds while no read is issued
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/hfps_cmp.sv
// ----------------------------------------------------------------------------
// hfps_cmp
// Shared comparator: free space against need, stored key against search key.
// ----------------------------------------------------------------------------
module hfps_cmp
    import hfps_pkg::*;
(
    input  logic [KEY_W-1:0] i_a,
    input  logic [KEY_W-1:0] i_b,
    output logic             o_ge,
    output logic             o_eq
);

    always_comb begin
        o_ge = (i_a >= i_b);
        o_eq = (i_a == i_b);
    end

endmodule

>>> rtl/hfps_seq.sv
// ----------------------------------------------------------------------------
// hfps_seq
// Sequencer with page table: first-fit insert, slot scan search, status walk.
// ----------------------------------------------------------------------------
module hfps_seq
    import hfps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [BYTES_W-1:0] i_usable,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_op,
    input  logic [BYTES_W-1:0] i_bytes,
    input  logic [KEY_W-1:0]   i_key,
    output logic [KEY_W-1:0]   o_cmp_a,
    output logic [KEY_W-1:0]   o_cmp_b,
    input  logic               i_ge,
    input  logic               i_eq,
    output t_ram_req           o_ram_req,
    input  logic [KEY_W-1:0]   i_rd_data,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output t_result            o_res,
    output logic [PCNT_W-1:0]  o_page_count
);

    t_state              r_state, n_state;
    logic [PCNT_W-1:0]   r_pc, n_pc;
    logic [PCNT_W-1:0]   r_pg, n_pg;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [NEED_W-1:0]   r_need, n_need;
    logic [KEY_W-1:0]    r_key, n_key;
    logic                r_ov, n_ov;
    t_result             r_res;

    logic [BYTES_W-1:0]  r_free [MAX_PAGES];
    logic [FILL_W-1:0]   r_fill [MAX_PAGES];

    logic                tbl_we;
    logic [BYTES_W-1:0]  tbl_free;
    logic [FILL_W-1:0]   tbl_fill;
    logic [PAGE_W-1:0]   pg_idx;
    logic [FILL_W-1:0]   cur_fill;
    logic [BYTES_W-1:0]  cur_free;
    logic                can_emit;
    logic                emit;
    t_result             e_res;

    assign pg_idx   = r_pg[PAGE_W-1:0];
    assign cur_fill = r_fill[pg_idx];
    assign cur_free = r_free[pg_idx];
    assign can_emit = !r_ov || i_res_ready;

    always_comb begin
        n_state   = r_state;
        n_pc      = r_pc;
        n_pg      = r_pg;
        n_slot    = r_slot;
        n_need    = r_need;
        n_key     = r_key;
        o_cmp_a   = '0;
        o_cmp_b   = '0;
        o_ram_req = '0;
        tbl_we    = 1'b0;
        tbl_free  = cur_free;
        tbl_fill  = cur_fill;
        emit      = 1'b0;
        e_res     = '0;
        e_res.outcome = OC_OK;
        e_res.last    = 1'b1;
        e_res.pages   = r_pc;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_need = NEED_W'(i_bytes) + NEED_W'(SLOT_OVERHEAD);
                    n_key  = i_key;
                    n_pg   = '0;
                    n_slot = '0;
                    case (t_op'(i_op))
                        OP_INSERT: n_state = S_INS_SCAN;
                        OP_SEARCH: n_state = S_SRCH_PAGE;
                        OP_STATUS: n_state = S_STATUS;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end

            S_INS_SCAN: begin
                o_cmp_b = KEY_W'(r_need);
                if (r_pg != r_pc) begin
                    o_cmp_a = KEY_W'(cur_free);
                    if (i_ge && (cur_fill < FILL_W'(SLOTS_PER_PAGE))) begin
                        if (can_emit) begin
                            o_ram_req.we    = 1'b1;
                            o_ram_req.waddr = {pg_idx, cur_fill[SLOT_W-1:0]};
                            o_ram_req.wdata = r_key;
                            tbl_we   = 1'b1;
                            tbl_free = cur_free - r_need[BYTES_W-1:0];
                            tbl_fill = cur_fill + FILL_W'(1);
                            emit          = 1'b1;
                            e_res.found   = 1'b1;
                            e_res.page    = pg_idx;
                            e_res.slot    = cur_fill[SLOT_W-1:0];
                            n_state       = S_IDLE;
                        end
                    end else begin
                        n_pg = r_pg + PCNT_W'(1);
                    end
                end else if (r_pc == PCNT_W'(MAX_PAGES)) begin
                    if (can_emit) begin
                        emit          = 1'b1;
                        e_res.outcome = OC_PAGE_LIMIT;
                        n_state       = S_IDLE;
                    end
                end else begin
                    // open a fresh page at the end of the file
                    o_cmp_a = KEY_W'(i_usable);
                    if (can_emit) begin
                        n_pc        = r_pc + PCNT_W'(1);
                        e_res.pages = n_pc;
                        e_res.page  = pg_idx;
                        tbl_we      = 1'b1;
                        emit        = 1'b1;
                        n_state     = S_IDLE;
                        if (i_ge) begin
                            o_ram_req.we    = 1'b1;
                            o_ram_req.waddr = {pg_idx, SLOT_W'(0)};
                            o_ram_req.wdata = r_key;
                            tbl_free    = i_usable - r_need[BYTES_W-1:0];
                            tbl_fill    = FILL_W'(1);
                            e_res.found = 1'b1;
                        end else begin
                            tbl_free      = i_usable;
                            tbl_fill      = '0;
                            e_res.outcome = OC_TOO_LARGE;
                        end
                    end
                end
            end

            S_SRCH_PAGE: begin
                if (r_pg == r_pc) begin
                    if (can_emit) begin
                        emit    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (cur_fill == '0) begin
                    n_pg = r_pg + PCNT_W'(1);
                end else begin
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = {pg_idx, SLOT_W'(0)};
                    n_slot          = '0;
                    n_state         = S_SRCH_CMP;
                end
            end

            S_SRCH_CMP: begin
                o_cmp_a = i_rd_data;
                o_cmp_b = r_key;
                if (i_eq) begin
                    if (can_emit) begin
                        emit        = 1'b1;
                        e_res.found = 1'b1;
                        e_res.page  = pg_idx;
                        e_res.slot  = r_slot;
                        n_state     = S_IDLE;
                    end
                end else if ((FILL_W'(r_slot) + FILL_W'(1)) < cur_fill) begin
                    // next slot of the same page, one read per cycle
                    n_slot          = r_slot + SLOT_W'(1);
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = {pg_idx, n_slot};
                end else begin
                    n_pg    = r_pg + PCNT_W'(1);
                    n_slot  = '0;
                    n_state = S_SRCH_PAGE;
                end
            end

            S_STATUS: begin
                if (can_emit) begin
                    emit = 1'b1;
                    if (r_pc == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        e_res.page = pg_idx;
                        e_res.recs = cur_fill;
                        e_res.last = ((r_pg + PCNT_W'(1)) == r_pc);
                        if (e_res.last) begin
                            n_state = S_IDLE;
                        end else begin
                            n_pg = r_pg + PCNT_W'(1);
                        end
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase

        if (emit) begin
            n_ov = 1'b1;
        end else if (i_res_ready) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pg   <= n_pg;
        r_slot <= n_slot;
        r_need <= n_need;
        r_key  <= n_key;
        if (emit) begin
            r_res <= e_res;
        end
        if (tbl_we) begin
            r_free[pg_idx] <= tbl_free;
            r_fill[pg_idx] <= tbl_fill;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_res_valid  = r_ov;
    assign o_res        = r_res;
    assign o_page_count = r_pc;

endmodule

>>> rtl/heap_file_page_store.sv
// ----------------------------------------------------------------------------
// heap_file_page_store
// Heap file of pages with first-fit insert, key search and per-page status.
// ----------------------------------------------------------------------------
// One request is worked on at a time; s_axis_tready is high only between
// requests, and a finished result sits in an output register so the next
// request can be taken before it is collected. Insert checks one page per
// cycle against the shared comparator, and holds at its final step while the
// last result is still uncollected. Search reads the key memory once per
// stored slot of each page in use. Status gives one result per cycle per page
// while the sink keeps up. The page size register must be written through the
// cfg port between requests only; the block itself does not enforce this. A
// request of op code 3 is taken and dropped. No memory clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
module heap_file_page_store
    import hfps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,     // page_bytes
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [47:0]      s_axis_tdata,   // record_bytes[11:0], key[43:12], zero
    input  logic [1:0]       s_axis_tuser,   // op[1:0]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // outcome[1:0], found[2], page_index[6:3],
                                             // slot_index[12:7], pages_in_use[17:13],
                                             // records_on_page[24:18], zero
    output logic             m_axis_tlast
);

    logic [BYTES_W-1:0] r_usable, n_usable;
    logic [KEY_W-1:0]   cmp_a, cmp_b;
    logic               cmp_ge, cmp_eq;
    t_ram_req           ram_req;
    logic [KEY_W-1:0]   rd_data;
    t_result            res;
    logic [PCNT_W-1:0]  page_count;

    // usable bytes per page, clamped to the largest page and net of the header
    always_comb begin
        if (i_cfg_data > CFG_W'(MAX_PAGE_BYTES)) begin
            n_usable = BYTES_W'(MAX_PAGE_BYTES - HDR_BYTES);
        end else if (i_cfg_data >= CFG_W'(HDR_BYTES)) begin
            n_usable = BYTES_W'(i_cfg_data - CFG_W'(HDR_BYTES));
        end else begin
            n_usable = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_usable <= BYTES_W'(MAX_PAGE_BYTES - HDR_BYTES);
        end else if (i_cfg_valid) begin
            r_usable <= n_usable;
        end
    end

    assign o_cfg_ready = 1'b1;

    hfps_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_usable     (r_usable),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_op         (s_axis_tuser),
        .i_bytes      (s_axis_tdata[BYTES_W-1:0]),
        .i_key        (s_axis_tdata[BYTES_W+KEY_W-1:BYTES_W]),
        .o_cmp_a      (cmp_a),
        .o_cmp_b      (cmp_b),
        .i_ge         (cmp_ge),
        .i_eq         (cmp_eq),
        .o_ram_req    (ram_req),
        .i_rd_data    (rd_data),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .o_res        (res),
        .o_page_count (page_count)
    );

    hfps_cmp u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_ge (cmp_ge),
        .o_eq (cmp_eq)
    );

    hfps_key_ram u_key_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    assign m_axis_tdata = {7'd0, res.recs, res.pages, res.slot, res.page,
                           res.found, res.outcome};
    assign m_axis_tlast = res.last;

    logic in_req;
    assign in_req = s_axis_tvalid && s_axis_tready;

    a_page_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        page_count <= PCNT_W'(MAX_PAGES))
        else $error("page count beyond page limit");

    a_found_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && res.found) |-> (res.outcome == OC_OK))
        else $error("hit reported with a failure outcome");

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_req && (s_axis_tuser == OP_INSERT || s_axis_tuser == OP_SEARCH ||
                    s_axis_tuser == OP_STATUS)) |=> !s_axis_tready)
        else $error("request accepted while previous one still running");

endmodule

>>> sim/tb_heap_file_page_store.sv
// ----------------------------------------------------------------------------
// tb_heap_file_page_store
// Self-checking bench for the heap file page store.
// ----------------------------------------------------------------------------
// A short table of directed requests is followed by random phases, each run
// with its own page size. Every accepted request goes through a local
// first-fit page model. The model's results are queued and compared field by
// field with what leaves the master stream. Both stream sides idle in random
// bursts, except in the final phase.
// ----------------------------------------------------------------------------
module tb_heap_file_page_store;
    import hfps_pkg::*;

    localparam logic [1:0] OP_IGNORED     = 2'd3;
    localparam int         SETTLE_CYCLES  = 16;
    localparam int         TAIL_CYCLES    = 50;
    localparam int         STALL_LIMIT    = 20000;
    localparam int         REPORT_LINES   = 40;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [47:0]      s_axis_tdata = '0;    // record_bytes[11:0], key[43:12], zero
    logic [1:0]       s_axis_tuser = '0;    // op[1:0]
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [31:0]      m_axis_tdata;         // outcome[1:0], found[2], page_index[6:3],
                                            // slot_index[12:7], pages_in_use[17:13],
                                            // records_on_page[24:18], zero
    logic             m_axis_tlast;

    heap_file_page_store dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // page file model
    // ------------------------------------------------------------------------
    int unsigned page_bytes_cfg = MAX_PAGE_BYTES;
    int          page_count;
    int          free_bytes [MAX_PAGES];
    int          slot_fill  [MAX_PAGES];
    logic [31:0] slot_keys  [MAX_PAGES][SLOTS_PER_PAGE];

    t_result     pending_results [$];
    logic [31:0] stored_keys [$];

    int mismatch_count = 0;
    bit idle_on = 1'b1;

    function automatic t_result make_result(t_outcome outcome, logic found, int page,
                                            int slot, int pages, int recs, logic last);
        t_result r;
        r.outcome = outcome;
        r.found   = found;
        r.page    = PAGE_W'(page);
        r.slot    = SLOT_W'(slot);
        r.pages   = PCNT_W'(pages);
        r.recs    = FILL_W'(recs);
        r.last    = last;
        return r;
    endfunction

    function automatic void queue_result(t_result r);
        pending_results = {pending_results, r};
    endfunction

    function automatic int usable_bytes();
        int p;
        p = (page_bytes_cfg > MAX_PAGE_BYTES) ? MAX_PAGE_BYTES : int'(page_bytes_cfg);
        return (p >= HDR_BYTES) ? p - HDR_BYTES : 0;
    endfunction

    function automatic void predict_page_store(logic [1:0] op, logic [11:0] rec_bytes,
                                               logic [31:0] key);
        int need;
        int p;
        int s;
        need = int'(rec_bytes) + SLOT_OVERHEAD;
        if (op == OP_INSERT) begin
            for (p = 0; p < page_count; p++) begin
                if (free_bytes[p] >= need && slot_fill[p] < SLOTS_PER_PAGE) begin
                    s = slot_fill[p];
                    slot_keys[p][s] = key;
                    slot_fill[p]++;
                    free_bytes[p] -= need;
                    queue_result(make_result(OC_OK, 1'b1, p, s, page_count, 0, 1'b1));
                    return;
                end
            end
            if (page_count >= MAX_PAGES) begin
                queue_result(make_result(OC_PAGE_LIMIT, 1'b0, 0, 0, page_count, 0, 1'b1));
                return;
            end
            // no page fits: open a fresh one, which may stay empty
            p = page_count;
            free_bytes[p] = usable_bytes();
            slot_fill[p]  = 0;
            page_count++;
            if (free_bytes[p] >= need) begin
                slot_keys[p][0] = key;
                slot_fill[p]    = 1;
                free_bytes[p]  -= need;
                queue_result(make_result(OC_OK, 1'b1, p, 0, page_count, 0, 1'b1));
            end else begin
                queue_result(make_result(OC_TOO_LARGE, 1'b0, p, 0, page_count, 0, 1'b1));
            end
        end else if (op == OP_SEARCH) begin
            for (p = 0; p < page_count; p++) begin
                for (s = 0; s < slot_fill[p]; s++) begin
                    if (slot_keys[p][s] == key) begin
                        queue_result(make_result(OC_OK, 1'b1, p, s, page_count, 0, 1'b1));
                        return;
                    end
                end
            end
            queue_result(make_result(OC_OK, 1'b0, 0, 0, page_count, 0, 1'b1));
        end else if (op == OP_STATUS) begin
            if (page_count == 0) begin
                queue_result(make_result(OC_OK, 1'b0, 0, 0, 0, 0, 1'b1));
            end else begin
                for (p = 0; p < page_count; p++) begin
                    queue_result(make_result(OC_OK, 1'b0, p, 0, page_count,
                                             slot_fill[p], (p + 1 == page_count)));
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (mismatch_count < REPORT_LINES)
            $display("mismatch @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result 0x%08h", m_axis_tdata));
            end else begin
                want = pending_results.pop_front();
                check_field("outcome", int'(m_axis_tdata[1:0]), int'(want.outcome));
                check_field("found", int'(m_axis_tdata[2]), int'(want.found));
                check_field("page_index", int'(m_axis_tdata[6:3]), int'(want.page));
                check_field("slot_index", int'(m_axis_tdata[12:7]), int'(want.slot));
                check_field("pages_in_use", int'(m_axis_tdata[17:13]), int'(want.pages));
                check_field("records_on_page", int'(m_axis_tdata[24:18]),
                            int'(want.recs));
                check_field("last", int'(m_axis_tlast), int'(want.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // sink back-pressure and watchdog
    // ------------------------------------------------------------------------
    int sink_stall = 0;

    always @(posedge i_clk) begin
        if (sink_stall > 0) begin
            sink_stall    <= sink_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            sink_stall    <= $urandom_range(0, 12);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("[heap_file_page_store] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // request driving
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [1:0] op, input logic [11:0] rec_bytes,
                                input logic [31:0] key, input bit typed,
                                input t_result want);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, key, rec_bytes};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_page_store(op, rec_bytes, key);
        // hand-written expectations replace the model's single result
        if (typed && op != OP_IGNORED)
            pending_results[pending_results.size() - 1] = want;
        if (op == OP_INSERT)
            stored_keys = {stored_keys, key};
    endtask

    // stop the sender, let the queue empty and the block settle, then reconfigure
    task automatic reconfigure(input logic [CFG_W-1:0] page_bytes);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= page_bytes;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid    <= 1'b0;
        page_bytes_cfg = page_bytes;
    endtask

    // ------------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------------
    typedef struct {
        logic [1:0]  op;
        logic [11:0] rec_bytes;
        logic [31:0] key;
        bit          typed;
        t_result     want;
    } t_plan_row;

    t_plan_row directed_plan [$];

    function automatic void plan(logic [1:0] op, logic [11:0] rec_bytes, logic [31:0] key);
        t_plan_row row;
        row.op        = op;
        row.rec_bytes = rec_bytes;
        row.key       = key;
        row.typed     = 1'b0;
        row.want      = '0;
        directed_plan = {directed_plan, row};
    endfunction

    function automatic void plan_typed(logic [1:0] op, logic [11:0] rec_bytes,
                                       logic [31:0] key, t_result want);
        plan(op, rec_bytes, key);
        directed_plan[$].typed = 1'b1;
        directed_plan[$].want  = want;
    endfunction

    // ------------------------------------------------------------------------
    // random phases
    // ------------------------------------------------------------------------
    function automatic logic [31:0] pick_key(int reuse_pct);
        if (stored_keys.size() != 0 && $urandom_range(0, 99) < reuse_pct)
            return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        return $urandom;
    endfunction

    function automatic logic [11:0] pick_record_bytes(int big_pct);
        int r;
        int u;
        r = $urandom_range(0, 99);
        u = usable_bytes();
        if (r < big_pct)
            return 12'($urandom_range(0, 4095));
        // sizes that just fit or just miss a fresh page
        if (r < big_pct + 10)
            return (u >= 5) ? 12'(u - 5 + $urandom_range(0, 2)) : 12'($urandom_range(0, 3));
        return 12'($urandom_range(0, 63));
    endfunction

    task automatic run_phase(input logic [CFG_W-1:0] page_bytes, input int big_pct,
                             input int count);
        int          n;
        int          r;
        logic [1:0]  op;
        logic [11:0] rec_bytes;
        logic [31:0] key;
        reconfigure(page_bytes);
        for (n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            op = (r < 45) ? OP_INSERT : (r < 80) ? OP_SEARCH :
                 (r < 92) ? OP_STATUS : OP_IGNORED;
            rec_bytes = pick_record_bytes(big_pct);
            key = pick_key((op == OP_SEARCH) ? 60 : 20);
            send_request(op, rec_bytes, key, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int i;
        page_count = 0;

        // fresh file, 4096-byte pages: 4080 usable
        plan_typed(OP_STATUS, 12'd0, 32'd0,
                   make_result(OC_OK, 1'b0, 0, 0, 0, 0, 1'b1));
        plan_typed(OP_SEARCH, 12'd0, 32'd0,
                   make_result(OC_OK, 1'b0, 0, 0, 0, 0, 1'b1));
        plan(OP_IGNORED, 12'hFFF, 32'hFFFF_FFFF);
        plan_typed(OP_INSERT, 12'd0, 32'h8000_0000,
                   make_result(OC_OK, 1'b1, 0, 0, 1, 0, 1'b1));
        plan_typed(OP_INSERT, 12'hFFF, 32'h7FFF_FFFF,
                   make_result(OC_TOO_LARGE, 1'b0, 1, 0, 2, 0, 1'b1));
        plan(OP_INSERT, 12'd4076, 32'hFFFF_FFFF);   // fills the empty page exactly
        plan(OP_INSERT, 12'd4072, 32'd1);           // fills page 0 exactly
        plan(OP_SEARCH, 12'd0, 32'h8000_0000);
        plan(OP_SEARCH, 12'd0, 32'hFFFF_FFFF);
        plan(OP_SEARCH, 12'd0, 32'h7FFF_FFFF);      // too-large record was never stored
        plan(OP_INSERT, 12'd0, 32'd5);
        plan(OP_INSERT, 12'd0, 32'd5);              // duplicate key
        plan(OP_SEARCH, 12'hFFF, 32'd5);            // first match wins
        plan(OP_INSERT, 12'hAAA, 32'h5555_5555);
        plan(OP_INSERT, 12'h555, 32'hAAAA_AAAA);
        plan(OP_STATUS, 12'h555, 32'h1234_5678);
        plan(OP_IGNORED, 12'd0, 32'd0);
        plan(OP_SEARCH, 12'd0, 32'hAAAA_AAAA);
        plan(OP_SEARCH, 12'd0, 32'h5555_5555);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < directed_plan.size(); i++)
            send_request(directed_plan[i].op, directed_plan[i].rec_bytes,
                         directed_plan[i].key, directed_plan[i].typed,
                         directed_plan[i].want);

        run_phase(13'd8191, 10, 70);   // above the 4096 cap
        run_phase(13'd20, 20, 40);     // smallest page that can hold a record
        run_phase(13'd300, 20, 40);
        run_phase(13'd15, 60, 40);     // no usable bytes, pages open empty
        run_phase(13'd0, 60, 40);
        idle_on = 1'b0;
        run_phase(13'd4096, 30, 60);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("[heap_file_page_store] OK");
        else
            $display("[heap_file_page_store] ERROR");
        $finish;
    end

endmodule
